// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Depends on nothing; a file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define FAC_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fall alert controller: assertion failed");

// Assertion on the house clock and reset names.
`define FAC_ASSERT(label, prop) \
  `FAC_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

// ----- rtl/core/fac_pkg.sv -----
// Package of the fall alert controller: widths, register indexes, mode codes, reset settings.
// Depends on nothing.
package fac_pkg;

  localparam int unsigned THR_W     = 32;  // squared magnitude thresholds
  localparam int unsigned TAN_W     = 16;  // tilt tan^2, Q8.8
  localparam int unsigned TICK_W    = 16;  // tick count settings
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMPACT_THR   = 3'd0,
    REG_NORMAL_THR   = 3'd1,
    REG_TILT_TAN_SQ  = 3'd2,
    REG_COUNTDOWN    = 3'd3,
    REG_BLINK_START  = 3'd4,
    REG_BLINK_IVL    = 3'd5,
    REG_NORMAL_HOLD  = 3'd6,
    REG_TILT_IVL     = 3'd7
  } cfg_reg_e;

  localparam logic [1:0] FALL_MODE_MON  = 2'd0;
  localparam logic [1:0] FALL_MODE_CD   = 2'd1;
  localparam logic [1:0] FALL_MODE_SENT = 2'd2;

  localparam logic [THR_W-1:0]  RST_IMPACT_THR  = 32'd67108864;
  localparam logic [THR_W-1:0]  RST_NORMAL_THR  = 32'd9437184;
  localparam logic [TAN_W-1:0]  RST_TILT_TAN_SQ = 16'd256;
  localparam logic [TICK_W-1:0] RST_COUNTDOWN   = 16'd5000;
  localparam logic [TICK_W-1:0] RST_BLINK_START = 16'd3000;
  localparam logic [TICK_W-1:0] RST_BLINK_IVL   = 16'd500;
  localparam logic [TICK_W-1:0] RST_NORMAL_HOLD = 16'd2000;
  localparam logic [TICK_W-1:0] RST_TILT_IVL    = 16'd500;

endpackage

// ----- rtl/core/fac_channels.sv -----
// Valid/ready channel interfaces for tick items and result items.
// Depends on nothing.
interface fac_in_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic                           sample_valid;
  logic signed [SAMPLE_WIDTH-1:0] accel_x;
  logic signed [SAMPLE_WIDTH-1:0] accel_y;
  logic signed [SAMPLE_WIDTH-1:0] accel_z;
  logic                           cancel_pressed;
  logic                           drowsy_active;

  modport source (
    output valid, sample_valid, accel_x, accel_y, accel_z, cancel_pressed, drowsy_active,
    input  ready
  );
  modport sink (
    input  valid, sample_valid, accel_x, accel_y, accel_z, cancel_pressed, drowsy_active,
    output ready
  );
endinterface

interface fac_out_if;
  logic       valid;
  logic       ready;
  logic       led_on;
  logic       buzzer_on;
  logic       send_alert;
  logic [1:0] fall_mode;
  logic       tilt_warning;

  modport source (
    output valid, led_on, buzzer_on, send_alert, fall_mode, tilt_warning,
    input  ready
  );
  modport sink (
    input  valid, led_on, buzzer_on, send_alert, fall_mode, tilt_warning,
    output ready
  );
endinterface

// ----- rtl/core/fac_mag_unit.sv -----
// Bit-serial shift-add unit: x^2, y^2+z^2 and tilt_tan_sq*(y^2+z^2).
// Depends on fac_pkg. One multiplier bit per cycle.
module fac_mag_unit #(
  parameter  int unsigned SAMPLE_WIDTH = 16,
  localparam int unsigned XX_W   = 2 * SAMPLE_WIDTH,
  localparam int unsigned YZ_W   = 2 * SAMPLE_WIDTH + 1,
  localparam int unsigned PROD_W = fac_pkg::TAN_W + YZ_W
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  accel_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  accel_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  accel_z_i,
  input  logic [fac_pkg::TAN_W-1:0]       tilt_tan_sq_i,
  output logic                            done_o,
  output logic [XX_W-1:0]                 xx_o,
  output logic [YZ_W-1:0]                 yz_o,
  output logic [PROD_W-1:0]               prod_o
);
  import fac_pkg::*;

  localparam int unsigned BW    = (SAMPLE_WIDTH > TAN_W) ? SAMPLE_WIDTH : TAN_W;
  localparam int unsigned CNT_W = $clog2(BW);

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_SQX  = 5'b00010,
    PH_SQY  = 5'b00100,
    PH_SQZ  = 5'b01000,
    PH_TAN  = 5'b10000
  } phase_e;

  function automatic logic [SAMPLE_WIDTH-1:0] mag_abs(logic signed [SAMPLE_WIDTH-1:0] v);
    logic [SAMPLE_WIDTH-1:0] u;
    u = v;
    return u[SAMPLE_WIDTH-1] ? (~u + 1'b1) : u;
  endfunction

  phase_e                  phase_q, phase_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [PROD_W-1:0]       a_q, a_d, acc_q, acc_d, sum;
  logic [BW-1:0]           b_q, b_d;
  logic [SAMPLE_WIDTH-1:0] ay_q, ay_d, az_q, az_d;
  logic [XX_W-1:0]         xx_q, xx_d;
  logic [YZ_W-1:0]         yz_q, yz_d;
  logic [PROD_W-1:0]       prod_q, prod_d;
  logic                    done;

  assign sum = acc_q + (b_q[0] ? a_q : '0);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q - 1'b1;
    a_d     = a_q << 1;
    b_d     = b_q >> 1;
    acc_d   = sum;
    ay_d    = ay_q;
    az_d    = az_q;
    xx_d    = xx_q;
    yz_d    = yz_q;
    prod_d  = prod_q;
    done    = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        cnt_d = cnt_q;
        a_d   = a_q;
        b_d   = b_q;
        acc_d = acc_q;
        if (start_i) begin
          phase_d = PH_SQX;
          a_d     = PROD_W'(mag_abs(accel_x_i));
          b_d     = BW'(mag_abs(accel_x_i));
          acc_d   = '0;
          cnt_d   = CNT_W'(SAMPLE_WIDTH - 1);
          ay_d    = mag_abs(accel_y_i);
          az_d    = mag_abs(accel_z_i);
        end
      end
      PH_SQX: begin
        if (cnt_q == '0) begin
          xx_d    = sum[XX_W-1:0];
          acc_d   = '0;
          a_d     = PROD_W'(ay_q);
          b_d     = BW'(ay_q);
          cnt_d   = CNT_W'(SAMPLE_WIDTH - 1);
          phase_d = PH_SQY;
        end
      end
      PH_SQY: begin
        // accumulator carries y^2 into the z pass
        if (cnt_q == '0) begin
          a_d     = PROD_W'(az_q);
          b_d     = BW'(az_q);
          cnt_d   = CNT_W'(SAMPLE_WIDTH - 1);
          phase_d = PH_SQZ;
        end
      end
      PH_SQZ: begin
        if (cnt_q == '0) begin
          yz_d    = sum[YZ_W-1:0];
          acc_d   = '0;
          a_d     = PROD_W'(sum[YZ_W-1:0]);
          b_d     = BW'(tilt_tan_sq_i);
          cnt_d   = CNT_W'(TAN_W - 1);
          phase_d = PH_TAN;
        end
      end
      PH_TAN: begin
        if (cnt_q == '0) begin
          prod_d  = sum;
          done    = 1'b1;
          phase_d = PH_IDLE;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
    ay_q   <= ay_d;
    az_q   <= az_d;
    xx_q   <= xx_d;
    yz_q   <= yz_d;
    prod_q <= prod_d;
  end

  assign done_o = done;
  assign xx_o   = xx_q;
  assign yz_o   = yz_q;
  assign prod_o = prod_q;

endmodule

// ----- rtl/core/fall_alert_controller_unit.sv -----
// Tick with a sample: the bit-serial shift-add unit runs four passes (one multiplier bit per cycle),
// then the compare state (ST_CMP) registers the compares and the update state (ST_EVAL) registers
// the result. Tick without a sample: the unit goes straight from ST_IDLE to ST_EVAL.
// One tick in flight at a time; the next tick is taken in ST_IDLE once the result is registered,
// and ST_EVAL holds while the output stalls.
// Reset (async, active low) restores default settings, monitoring mode and idle timers.
module fall_alert_controller_unit #(
  parameter int unsigned TIMER_WIDTH  = 16,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fac_in_if.sink                        in_ch,
  fac_out_if.source                     out_ch,
  input  logic                          cfg_we_i,
  input  logic [fac_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fac_pkg::CFG_W-1:0]     cfg_data_i
);
  import fac_pkg::*;

  localparam int unsigned XX_W   = 2 * SAMPLE_WIDTH;
  localparam int unsigned YZ_W   = 2 * SAMPLE_WIDTH + 1;
  localparam int unsigned MAG_W  = 2 * SAMPLE_WIDTH + 2;
  localparam int unsigned PROD_W = TAN_W + YZ_W;
  localparam int unsigned MCMP_W = (MAG_W > THR_W) ? MAG_W : THR_W;
  localparam int unsigned TCMP_W = (TIMER_WIDTH > TICK_W) ? TIMER_WIDTH : TICK_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_EVAL = 4'b1000
  } st_e;

  typedef enum logic [2:0] {
    MODE_MON  = 3'b001,
    MODE_CD   = 3'b010,
    MODE_SENT = 3'b100
  } mode_e;

  typedef logic [TIMER_WIDTH-1:0] tmr_t;

  function automatic tmr_t tmr_inc(tmr_t t);
    return (t == '1) ? t : t + 1'b1;
  endfunction

  function automatic logic tmr_ge(tmr_t t, logic [TICK_W-1:0] c);
    return TCMP_W'(t) >= TCMP_W'(c);
  endfunction

  // settings
  logic [THR_W-1:0]  impact_thr_q, normal_thr_q;
  logic [TAN_W-1:0]  tan_sq_q;
  logic [TICK_W-1:0] countdown_q, blink_start_q, blink_ivl_q, hold_q, tilt_ivl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      impact_thr_q  <= RST_IMPACT_THR;
      normal_thr_q  <= RST_NORMAL_THR;
      tan_sq_q      <= RST_TILT_TAN_SQ;
      countdown_q   <= RST_COUNTDOWN;
      blink_start_q <= RST_BLINK_START;
      blink_ivl_q   <= RST_BLINK_IVL;
      hold_q        <= RST_NORMAL_HOLD;
      tilt_ivl_q    <= RST_TILT_IVL;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_IMPACT_THR:  impact_thr_q  <= cfg_data_i[THR_W-1:0];
        REG_NORMAL_THR:  normal_thr_q  <= cfg_data_i[THR_W-1:0];
        REG_TILT_TAN_SQ: tan_sq_q      <= cfg_data_i[TAN_W-1:0];
        REG_COUNTDOWN:   countdown_q   <= cfg_data_i[TICK_W-1:0];
        REG_BLINK_START: blink_start_q <= cfg_data_i[TICK_W-1:0];
        REG_BLINK_IVL:   blink_ivl_q   <= cfg_data_i[TICK_W-1:0];
        REG_NORMAL_HOLD: hold_q        <= cfg_data_i[TICK_W-1:0];
        REG_TILT_IVL:    tilt_ivl_q    <= cfg_data_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencing
  st_e  st_q, st_d;
  logic in_fire, eval_fire, mul_done;
  logic samp_q, cancel_q, drowsy_q;

  assign in_ch.ready = (st_q == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign eval_fire   = (st_q == ST_EVAL) && (!out_ch.valid || out_ch.ready);

  logic [XX_W-1:0]   xx;
  logic [YZ_W-1:0]   yz;
  logic [PROD_W-1:0] prod;

  fac_mag_unit #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_mag (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (in_fire && in_ch.sample_valid),
    .accel_x_i     (in_ch.accel_x),
    .accel_y_i     (in_ch.accel_y),
    .accel_z_i     (in_ch.accel_z),
    .tilt_tan_sq_i (tan_sq_q),
    .done_o        (mul_done),
    .xx_o          (xx),
    .yz_o          (yz),
    .prod_o        (prod)
  );

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (in_fire) st_d = in_ch.sample_valid ? ST_MUL : ST_EVAL;
      ST_MUL:  if (mul_done) st_d = ST_CMP;
      ST_CMP:  st_d = ST_EVAL;
      ST_EVAL: if (eval_fire) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      samp_q   <= in_ch.sample_valid;
      cancel_q <= in_ch.cancel_pressed;
      drowsy_q <= in_ch.drowsy_active;
    end
  end

  // sample compares, registered ahead of the tick update
  logic [MAG_W-1:0] mag;
  logic             below_s_q, impact_s_q, tilt_s_q;

  assign mag = MAG_W'(xx) + MAG_W'(yz);

  always_ff @(posedge clk_i) begin
    if (st_q == ST_CMP) begin
      below_s_q  <= MCMP_W'(mag) < MCMP_W'(normal_thr_q);
      impact_s_q <= MCMP_W'(mag) > MCMP_W'(impact_thr_q);
      // all axes zero: tilt only for a zero tan^2 setting
      tilt_s_q   <= (mag == '0) ? (tan_sq_q == '0)
                                : (PROD_W'({xx, 8'h00}) >= prod);
    end
  end

  // tick state
  mode_e mode_q, mode_d;
  tmr_t  cd_q, cd_d, bt_q, bt_d, nt_q, nt_d, tt_q, tt_d;
  logic  ad_q, ad_d, bp_q, bp_d, nr_q, nr_d, bn_q, bn_d, tf_q, tf_d, tl_q, tl_d;
  logic  led, buzz, pulse;

  always_comb begin
    cd_d   = tmr_inc(cd_q);
    bt_d   = tmr_inc(bt_q);
    nt_d   = tmr_inc(nt_q);
    tt_d   = tmr_inc(tt_q);
    mode_d = mode_q;
    ad_d   = ad_q;
    bp_d   = bp_q;
    nr_d   = nr_q;
    bn_d   = bn_q;
    tf_d   = tf_q;
    tl_d   = tl_q;
    led    = 1'b0;
    buzz   = 1'b0;
    pulse  = 1'b0;

    if (samp_q) begin
      bn_d = below_s_q;
      tf_d = tilt_s_q;
      if (mode_q == MODE_MON && impact_s_q) begin
        mode_d = MODE_CD;
        cd_d   = '0;
        ad_d   = 1'b0;
        bp_d   = 1'b0;
        nr_d   = 1'b0;
      end
    end

    priority case (mode_d)
      MODE_CD: begin
        if (cancel_q) begin
          mode_d = MODE_MON;
        end else begin
          if (tmr_ge(cd_d, blink_start_q) && tmr_ge(bt_d, blink_ivl_q)) begin
            bp_d = !bp_d;
            bt_d = '0;
          end
          if (tmr_ge(cd_d, countdown_q)) begin
            if (!ad_d) begin
              pulse = 1'b1;
              ad_d  = 1'b1;
            end
            mode_d = MODE_SENT;
          end
        end
      end
      MODE_SENT: begin
        if (bn_d) begin
          if (!nr_d) begin
            nr_d = 1'b1;
            nt_d = '0;
          end else if (tmr_ge(nt_d, hold_q)) begin
            mode_d = MODE_MON;
            ad_d   = 1'b0;
            nr_d   = 1'b0;
          end
        end else begin
          nr_d = 1'b0;
        end
      end
      default: ;
    endcase

    // fall first, then drowsiness, then tilt blink
    if (mode_d == MODE_CD) begin
      buzz = 1'b1;
      led  = tmr_ge(cd_d, blink_start_q) ? bp_d : 1'b1;
    end else if (drowsy_q) begin
      buzz = 1'b1;
    end else if (tf_d) begin
      if (tmr_ge(tt_d, tilt_ivl_q)) begin
        tl_d = !tl_d;
        tt_d = '0;
      end
      led = tl_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      mode_q <= MODE_MON;
      cd_q   <= '0;
      bt_q   <= '1;
      nt_q   <= '0;
      tt_q   <= '1;
      ad_q   <= 1'b0;
      bp_q   <= 1'b0;
      nr_q   <= 1'b0;
      bn_q   <= 1'b1;
      tf_q   <= 1'b0;
      tl_q   <= 1'b0;
    end else begin
      st_q <= st_d;
      if (eval_fire) begin
        mode_q <= mode_d;
        cd_q   <= cd_d;
        bt_q   <= bt_d;
        nt_q   <= nt_d;
        tt_q   <= tt_d;
        ad_q   <= ad_d;
        bp_q   <= bp_d;
        nr_q   <= nr_d;
        bn_q   <= bn_d;
        tf_q   <= tf_d;
        tl_q   <= tl_d;
      end
    end
  end

  // output register
  logic       out_valid_q;
  logic       led_q, buzz_q, pulse_q, tilt_q;
  logic [1:0] fmode_q, fmode_d;

  always_comb begin
    unique case (mode_d)
      MODE_CD:   fmode_d = FALL_MODE_CD;
      MODE_SENT: fmode_d = FALL_MODE_SENT;
      default:   fmode_d = FALL_MODE_MON;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eval_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_fire) begin
      led_q   <= led;
      buzz_q  <= buzz;
      pulse_q <= pulse;
      fmode_q <= fmode_d;
      tilt_q  <= tf_d;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.led_on       = led_q;
  assign out_ch.buzzer_on    = buzz_q;
  assign out_ch.send_alert   = pulse_q;
  assign out_ch.fall_mode    = fmode_q;
  assign out_ch.tilt_warning = tilt_q;

endmodule

// ----- rtl/core/fac_checker.sv -----
// Port-level checks on the result channel of the fall alert controller, with its bind.
// Depends on fac_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fac_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       led_on_i,
  input logic       buzzer_on_i,
  input logic       send_alert_i,
  input logic [1:0] fall_mode_i,
  input logic       tilt_warning_i
);
  import fac_pkg::*;

  // a stalled beat holds
  `FAC_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(led_on_i) && $stable(buzzer_on_i) && $stable(send_alert_i) && $stable(fall_mode_i) && $stable(tilt_warning_i))

  // the alert pulse comes with the move to alert-sent
  `FAC_ASSERT(a_pulse_mode, out_valid_i && send_alert_i |-> fall_mode_i == FALL_MODE_SENT)

  // countdown always sounds the buzzer
  `FAC_ASSERT(a_cd_buzz, out_valid_i && fall_mode_i == FALL_MODE_CD |-> buzzer_on_i)

  // the pulse never lasts two beats in a row
  `FAC_ASSERT(a_pulse_single, out_valid_i && out_ready_i && send_alert_i |=> !(out_valid_i && send_alert_i))

endmodule

bind fall_alert_controller_unit fac_checker u_fac_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_ch.valid),
  .out_ready_i    (out_ch.ready),
  .led_on_i       (out_ch.led_on),
  .buzzer_on_i    (out_ch.buzzer_on),
  .send_alert_i   (out_ch.send_alert),
  .fall_mode_i    (out_ch.fall_mode),
  .tilt_warning_i (out_ch.tilt_warning)
);
